FILE: hdl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// types and constants shared by the single-wire bus master and its channels
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int unsigned MODE_W = 2;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TICK_W = 10;
    localparam int unsigned REG_W  = 3;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned BIT_W  = 4;
    localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_RESET = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [REG_W-1:0] {
        REG_RESET_LOW    = 3'd0,
        REG_PRES_SAMPLE  = 3'd1,
        REG_RESET_TAIL   = 3'd2,
        REG_SLOT_START   = 3'd3,
        REG_WRITE_HOLD   = 3'd4,
        REG_WRITE_REC    = 3'd5,
        REG_READ_SAMPLE  = 3'd6,
        REG_READ_TAIL    = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W_START  = 4'd4,
        PH_W_HOLD   = 4'd5,
        PH_W_REC    = 4'd6,
        PH_R_START  = 4'd7,
        PH_R_WAIT   = 4'd8,
        PH_R_TAIL   = 4'd9
    } t_phase;

    typedef logic [TICK_W-1:0] t_ticks;

    localparam t_ticks RESET_LOW_DEF    = 10'd800;
    localparam t_ticks PRES_SAMPLE_DEF  = 10'd80;
    localparam t_ticks RESET_TAIL_DEF   = 10'd200;
    localparam t_ticks SLOT_START_DEF   = 10'd5;
    localparam t_ticks WRITE_HOLD_DEF   = 10'd60;
    localparam t_ticks WRITE_REC_DEF    = 10'd5;
    localparam t_ticks READ_SAMPLE_DEF  = 10'd20;
    localparam t_ticks READ_TAIL_DEF    = 10'd60;

    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [BYTE_W-1:0] read_byte;
    } t_result;

endpackage

FILE: hdl/owm_if.sv
// ----------------------------------------------------------------------------
// owm channel interfaces
// valid/ready channels for command and tick items, results and register writes
// ----------------------------------------------------------------------------
interface owm_in_if
    import owm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] data_byte;
    logic              line_in;

    modport source (output valid, output mode, output data_byte, output line_in,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input line_in,
                    output ready);
endinterface

interface owm_out_if
    import owm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence;
    logic [BYTE_W-1:0] read_byte;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_byte, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_byte, output ready);
endinterface

interface owm_cfg_if
    import owm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REG_W-1:0]  index;
    logic [TICK_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/one_wire_bus_master.sv
// the result of an accepted item shows on o_out in the cycle after
// one item per clock while o_out is ready; the result register frees as taken
// timing state (phase, tick counter, bit index, shift byte) updates in the
// cycle an item is accepted, and the result register holds the outcome
// reset: synchronous, active low; idle phase, counters and flags cleared,
// timing registers loaded with their default tick counts
// ----------------------------------------------------------------------------
// one_wire_bus_master
// single-wire open-drain bus master: reset/presence, byte write, byte read
// ----------------------------------------------------------------------------
module one_wire_bus_master
    import owm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    owm_in_if.sink       i_in,
    owm_cfg_if.sink      i_cfg,
    owm_out_if.source    o_out
);

    t_ticks            r_cfg [NUM_REGS];
    t_phase            r_phase, n_phase;
    t_ticks            r_tick, n_tick;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic              r_pres, n_pres;
    logic [BYTE_W-1:0] r_rdbyte, n_rdbyte;
    logic              n_done;
    logic              r_out_valid;
    t_result           r_out, n_out;

    t_ticks            w_len;
    t_ticks            w_tick_inc;
    logic [BIT_W-1:0]  w_bit_inc;
    logic              w_in_acc;
    logic              w_out_acc;
    t_mode             w_mode;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_acc   = r_out_valid && o_out.ready;
    assign w_mode      = t_mode'(i_in.mode);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_RESET_LOW]   <= RESET_LOW_DEF;
            r_cfg[REG_PRES_SAMPLE] <= PRES_SAMPLE_DEF;
            r_cfg[REG_RESET_TAIL]  <= RESET_TAIL_DEF;
            r_cfg[REG_SLOT_START]  <= SLOT_START_DEF;
            r_cfg[REG_WRITE_HOLD]  <= WRITE_HOLD_DEF;
            r_cfg[REG_WRITE_REC]   <= WRITE_REC_DEF;
            r_cfg[REG_READ_SAMPLE] <= READ_SAMPLE_DEF;
            r_cfg[REG_READ_TAIL]   <= READ_TAIL_DEF;
        end else if (i_cfg.valid) begin
            r_cfg[i_cfg.index] <= i_cfg.data;
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_RST_LOW:  w_len = r_cfg[REG_RESET_LOW];
            PH_RST_WAIT: w_len = r_cfg[REG_PRES_SAMPLE];
            PH_RST_TAIL: w_len = r_cfg[REG_RESET_TAIL];
            PH_W_START:  w_len = r_cfg[REG_SLOT_START];
            PH_W_HOLD:   w_len = r_cfg[REG_WRITE_HOLD];
            PH_W_REC:    w_len = r_cfg[REG_WRITE_REC];
            PH_R_START:  w_len = r_cfg[REG_SLOT_START];
            PH_R_WAIT:   w_len = r_cfg[REG_READ_SAMPLE];
            PH_R_TAIL:   w_len = r_cfg[REG_READ_TAIL];
            default:     w_len = t_ticks'(1);
        endcase
    end

    assign w_tick_inc = r_tick + t_ticks'(1);
    assign w_bit_inc  = r_bit + BIT_W'(1);

    // next state for one item
    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_pres   = r_pres;
        n_rdbyte = r_rdbyte;
        n_done   = 1'b0;
        if (w_mode == MODE_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (w_tick_inc < w_len) begin
                    n_tick = w_tick_inc;
                end else begin
                    n_tick = '0;
                    unique case (r_phase)
                        PH_RST_LOW: begin
                            n_phase = PH_RST_WAIT;
                        end
                        PH_RST_WAIT: begin
                            n_pres  = !i_in.line_in;
                            n_phase = PH_RST_TAIL;
                        end
                        PH_RST_TAIL: begin
                            if (r_pres) begin
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end else begin
                                n_phase = PH_RST_LOW;
                            end
                        end
                        PH_W_START: begin
                            n_phase = PH_W_HOLD;
                        end
                        PH_W_HOLD: begin
                            n_phase = PH_W_REC;
                        end
                        PH_W_REC: begin
                            n_shift = r_shift >> 1;
                            n_bit   = w_bit_inc;
                            if (w_bit_inc >= BITS_PER_BYTE) begin
                                n_phase = PH_IDLE;
                                n_done  = 1'b1;
                            end else begin
                                n_phase = PH_W_START;
                            end
                        end
                        PH_R_START: begin
                            n_phase = PH_R_WAIT;
                        end
                        PH_R_WAIT: begin
                            n_shift = {i_in.line_in, r_shift[BYTE_W-1:1]};
                            n_phase = PH_R_TAIL;
                        end
                        PH_R_TAIL: begin
                            n_bit = w_bit_inc;
                            if (w_bit_inc >= BITS_PER_BYTE) begin
                                n_rdbyte = r_shift;
                                n_phase  = PH_IDLE;
                                n_done   = 1'b1;
                            end else begin
                                n_phase = PH_R_START;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
        end else if (r_phase == PH_IDLE) begin
            n_bit  = '0;
            n_tick = '0;
            unique case (w_mode)
                MODE_RESET: begin
                    n_pres  = 1'b0;
                    n_phase = PH_RST_LOW;
                end
                MODE_WRITE: begin
                    n_shift = i_in.data_byte;
                    n_phase = PH_W_START;
                end
                default: begin
                    n_shift = '0;
                    n_phase = PH_R_START;
                end
            endcase
        end
    end

    always_comb begin
        unique case (n_phase)
            PH_RST_LOW, PH_W_START, PH_R_START: n_out.drive_low = 1'b1;
            PH_W_HOLD:                          n_out.drive_low = !n_shift[0];
            default:                            n_out.drive_low = 1'b0;
        endcase
        n_out.busy_res  = (n_phase != PH_IDLE);
        n_out.done_res  = n_done;
        n_out.presence  = n_pres;
        n_out.read_byte = n_rdbyte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_pres      <= 1'b0;
            r_rdbyte    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_phase  <= n_phase;
                r_tick   <= n_tick;
                r_bit    <= n_bit;
                r_shift  <= n_shift;
                r_pres   <= n_pres;
                r_rdbyte <= n_rdbyte;
            end
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_low = r_out.drive_low;
    assign o_out.busy_res  = r_out.busy_res;
    assign o_out.done_res  = r_out.done_res;
    assign o_out.presence  = r_out.presence;
    assign o_out.read_byte = r_out.read_byte;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done item still shows busy");

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick == '0))
        else $error("tick counter not cleared in idle");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= BITS_PER_BYTE)
        else $error("bit index beyond one byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !w_in_acc)
        else $error("item accepted over a pending result");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid)
        else $error("accepted item produced no result");
`endif

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench for one_wire_bus_master
// drives command and tick items with bursty gaps, stalls the result channel,
// predicts every result from a cycle-free model of the slot timing and checks
// each field of each result in order; covers default, minimum and zero
// timing registers and random traffic under random timing settings
// ----------------------------------------------------------------------------
module testbench;
    import owm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 8_000_000;
    localparam int unsigned HOLDOFF_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    owm_in_if  in_ch ();
    owm_out_if out_ch ();
    owm_cfg_if cfg_ch ();

    one_wire_bus_master i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bus master prediction state
    t_phase       bm_phase;
    t_ticks       bm_ticks;
    logic [3:0]   bm_bit;
    logic [7:0]   bm_shift;
    logic         bm_present;
    logic [7:0]   bm_last_read;
    t_ticks       tick_reg [NUM_REGS];

    t_result      expected_results [$];
    int unsigned  fail_count = 0;
    int unsigned  cycle_count = 0;

    // traffic shaping
    int           tx_gap_max = 3;
    int           burst_left = 0;
    bit           rx_stall_on = 1'b1;
    bit           holdoff_active = 1'b0;
    int           stall_left = 0;
    logic [15:0]  stall_pattern = '1;
    event         holdoff_ev;

    function automatic t_ticks slot_length(input t_phase ph);
        case (ph)
            PH_RST_LOW:  return tick_reg[REG_RESET_LOW];
            PH_RST_WAIT: return tick_reg[REG_PRES_SAMPLE];
            PH_RST_TAIL: return tick_reg[REG_RESET_TAIL];
            PH_W_START:  return tick_reg[REG_SLOT_START];
            PH_W_HOLD:   return tick_reg[REG_WRITE_HOLD];
            PH_W_REC:    return tick_reg[REG_WRITE_REC];
            PH_R_START:  return tick_reg[REG_SLOT_START];
            PH_R_WAIT:   return tick_reg[REG_READ_SAMPLE];
            PH_R_TAIL:   return tick_reg[REG_READ_TAIL];
            default:     return t_ticks'(1);
        endcase
    endfunction

    function automatic void enter_phase(input t_phase ph);
        bm_phase = ph;
        bm_ticks = '0;
    endfunction

    function automatic t_result bus_master_step(input t_mode m, input logic [7:0] d,
                                                input logic line);
        t_result r;
        logic    done;
        done = 1'b0;
        if (m == MODE_TICK) begin
            if (bm_phase != PH_IDLE) begin
                bm_ticks = bm_ticks + 1'b1;
                if (bm_ticks >= slot_length(bm_phase)) begin
                    case (bm_phase)
                        PH_RST_LOW:  enter_phase(PH_RST_WAIT);
                        PH_RST_WAIT: begin
                            bm_present = ~line;
                            enter_phase(PH_RST_TAIL);
                        end
                        PH_RST_TAIL: begin
                            if (bm_present) begin
                                enter_phase(PH_IDLE);
                                done = 1'b1;
                            end else begin
                                enter_phase(PH_RST_LOW);
                            end
                        end
                        PH_W_START:  enter_phase(PH_W_HOLD);
                        PH_W_HOLD:   enter_phase(PH_W_REC);
                        PH_W_REC: begin
                            bm_shift = bm_shift >> 1;
                            bm_bit = bm_bit + 1'b1;
                            if (bm_bit >= BITS_PER_BYTE) begin
                                enter_phase(PH_IDLE);
                                done = 1'b1;
                            end else begin
                                enter_phase(PH_W_START);
                            end
                        end
                        PH_R_START:  enter_phase(PH_R_WAIT);
                        PH_R_WAIT: begin
                            bm_shift = {line, bm_shift[7:1]};
                            enter_phase(PH_R_TAIL);
                        end
                        PH_R_TAIL: begin
                            bm_bit = bm_bit + 1'b1;
                            if (bm_bit >= BITS_PER_BYTE) begin
                                bm_last_read = bm_shift;
                                enter_phase(PH_IDLE);
                                done = 1'b1;
                            end else begin
                                enter_phase(PH_R_START);
                            end
                        end
                        default:     enter_phase(PH_IDLE);
                    endcase
                end
            end
        end else if (bm_phase == PH_IDLE) begin
            bm_bit = '0;
            case (m)
                MODE_RESET: begin
                    bm_present = 1'b0;
                    enter_phase(PH_RST_LOW);
                end
                MODE_WRITE: begin
                    bm_shift = d;
                    enter_phase(PH_W_START);
                end
                default: begin
                    bm_shift = '0;
                    enter_phase(PH_R_START);
                end
            endcase
        end
        case (bm_phase)
            PH_RST_LOW, PH_W_START, PH_R_START: r.drive_low = 1'b1;
            PH_W_HOLD:                          r.drive_low = ~bm_shift[0];
            default:                            r.drive_low = 1'b0;
        endcase
        r.busy_res  = (bm_phase != PH_IDLE);
        r.done_res  = done;
        r.presence  = bm_present;
        r.read_byte = bm_last_read;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (want_v !== got_v) begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want_v, got_v);
        end
    endfunction

    // sends one item, with a random gap at the start of each burst
    task automatic send_item(input t_mode m, input logic [7:0] d, input logic line);
        int      gap;
        t_result r;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     = 1'b1;
        in_ch.mode      = m;
        in_ch.data_byte = d;
        in_ch.line_in   = line;
        do @(posedge i_clk); while (!in_ch.ready);
        r = bus_master_step(m, d, line);
        expected_results.push_back(r);
    endtask

    // ticks until the current operation ends; presence is always answered
    task automatic run_to_idle(input bit fixed, input logic level);
        logic line;
        while (bm_phase != PH_IDLE) begin
            if (bm_phase == PH_RST_WAIT)
                line = 1'b0;
            else if (fixed)
                line = level;
            else
                line = $urandom_range(0, 1);
            send_item(MODE_TICK, $urandom_range(0, 255), line);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input t_ticks v);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tick_reg[idx] = v;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_all_regs(input t_ticks v);
        t_reg_idx idx;
        idx = idx.first();
        do begin
            write_reg(idx, v);
            idx = idx.next();
        end while (idx != idx.first());
    endtask

    task automatic test_defaults_and_ignored();
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_item(MODE_TICK, 8'hFF, 1'b1);
        send_item(MODE_WRITE, 8'h5A, 1'b1);
        send_item(MODE_RESET, 8'h00, 1'b0);
        send_item(MODE_READ, 8'h00, 1'b0);
        send_item(MODE_WRITE, 8'hFF, 1'b1);
        send_item(MODE_TICK, 8'h00, 1'b0);
        run_to_idle(1'b0, 1'b0);
        settle();
    endtask

    task automatic test_min_timing();
        set_all_regs(10'd1);
        send_item(MODE_RESET, 8'h00, 1'b0);
        send_item(MODE_TICK, 8'hFF, 1'b0);
        // no presence, so the reset pulse repeats
        send_item(MODE_TICK, 8'h00, 1'b1);
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_item(MODE_TICK, 8'h00, 1'b1);
        send_item(MODE_TICK, 8'h00, 1'b0);
        send_item(MODE_TICK, 8'h00, 1'b1);
        send_item(MODE_WRITE, 8'h00, 1'b1);
        run_to_idle(1'b1, 1'b1);
        send_item(MODE_WRITE, 8'hFF, 1'b0);
        run_to_idle(1'b1, 1'b0);
        send_item(MODE_READ, 8'h00, 1'b0);
        run_to_idle(1'b1, 1'b1);
        send_item(MODE_READ, 8'hFF, 1'b1);
        run_to_idle(1'b1, 1'b0);
        settle();
    endtask

    task automatic test_zero_timing();
        set_all_regs(10'd0);
        send_item(MODE_WRITE, $urandom_range(0, 255), 1'b0);
        run_to_idle(1'b0, 1'b0);
        send_item(MODE_READ, 8'h3C, 1'b1);
        run_to_idle(1'b0, 1'b0);
        send_item(MODE_RESET, 8'h00, 1'b1);
        run_to_idle(1'b0, 1'b0);
        settle();
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int gap_max,
                                       input bit stall_on, input bit pressure);
        t_reg_idx    idx;
        int          pick;
        int unsigned counted;
        t_mode       m;
        logic        line;
        idx = idx.first();
        do begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                write_reg(idx, 10'd0);
            else if (pick < 12)
                write_reg(idx, t_ticks'($urandom_range(1, 3)));
            else if (pick < 18)
                write_reg(idx, t_ticks'($urandom_range(4, 12)));
            else
                write_reg(idx, t_ticks'($urandom_range(13, 40)));
            idx = idx.next();
        end while (idx != idx.first());
        tx_gap_max  = gap_max;
        rx_stall_on = stall_on;
        if (pressure)
            -> holdoff_ev;
        counted = 0;
        while (counted < n_items) begin
            if (bm_phase == PH_IDLE)
                m = ($urandom_range(0, 6) == 0) ? MODE_TICK : t_mode'($urandom_range(1, 3));
            else
                m = ($urandom_range(0, 12) == 0) ? t_mode'($urandom_range(1, 3)) : MODE_TICK;
            // idle ticks and commands while busy are noise
            if ((m == MODE_TICK) != (bm_phase == PH_IDLE))
                counted++;
            if (bm_phase == PH_RST_WAIT)
                line = ($urandom_range(0, 9) < 3);
            else
                line = $urandom_range(0, 1);
            send_item(m, $urandom_range(0, 255), line);
        end
        run_to_idle(1'b0, 1'b0);
        settle();
    endtask

    // result side: stall pattern per window, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = 48;
            if (rx_stall_on && $urandom_range(0, 2) != 0)
                stall_pattern = 16'($urandom()) | 16'h0001;
            else
                stall_pattern = '1;
        end
        stall_left--;
        out_ch.ready = !holdoff_active && stall_pattern[stall_left % 16];
    end

    initial begin
        forever begin
            @(holdoff_ev);
            holdoff_active = 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            holdoff_active = 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual %0b %0b %0b %0b %0h",
                         $time, out_ch.drive_low, out_ch.busy_res, out_ch.done_res,
                         out_ch.presence, out_ch.read_byte);
            end else begin
                want = expected_results.pop_front();
                check_field("drive_low", want.drive_low, out_ch.drive_low);
                check_field("busy_res", want.busy_res, out_ch.busy_res);
                check_field("done_res", want.done_res, out_ch.done_res);
                check_field("presence", want.presence, out_ch.presence);
                check_field("read_byte", want.read_byte, out_ch.read_byte);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** one_wire_bus_master: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_TICK;
        in_ch.data_byte = '0;
        in_ch.line_in   = 1'b1;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_RESET_LOW;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;

        bm_phase     = PH_IDLE;
        bm_ticks     = '0;
        bm_bit       = '0;
        bm_shift     = '0;
        bm_present   = 1'b0;
        bm_last_read = '0;
        tick_reg[REG_RESET_LOW]   = RESET_LOW_DEF;
        tick_reg[REG_PRES_SAMPLE] = PRES_SAMPLE_DEF;
        tick_reg[REG_RESET_TAIL]  = RESET_TAIL_DEF;
        tick_reg[REG_SLOT_START]  = SLOT_START_DEF;
        tick_reg[REG_WRITE_HOLD]  = WRITE_HOLD_DEF;
        tick_reg[REG_WRITE_REC]   = WRITE_REC_DEF;
        tick_reg[REG_READ_SAMPLE] = READ_SAMPLE_DEF;
        tick_reg[REG_READ_TAIL]   = READ_TAIL_DEF;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults_and_ignored();
        test_min_timing();
        test_zero_timing();
        test_random_traffic(120, 0, 1'b0, 1'b0);
        test_random_traffic(120, 4, 1'b1, 1'b0);
        test_random_traffic(120, 6, 1'b1, 1'b1);
        test_random_traffic(120, 2, 1'b0, 1'b0);
        test_random_traffic(130, 5, 1'b1, 1'b1);
        settle();

        if (fail_count == 0 && expected_results.size() == 0)
            $display("** one_wire_bus_master: PASSED **");
        else
            $display("** one_wire_bus_master: FAILED **");
        $finish;
    end

endmodule
